// ===== src/assert_macros.svh =====
// Assertion macros shared by the buzzer sequencer RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define BMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bms_pkg.sv =====
// Package for the buzzer melody sequencer: types, codes and constant tables.
// Used by the top, bms_core and bms_out_buf through scoped names; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bms_pkg;

  localparam int TUNE_COUNT = 7;
  localparam int MAX_NOTES  = 5;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_CHIRP = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TUNE  = 2'd1,
    MODE_CHIRP = 2'd2
  } mode_t;

  localparam logic CFG_ENABLED = 1'b0;
  localparam logic CFG_VOLUME  = 1'b1;

  localparam logic [6:0] VOLUME_MAX   = 7'd100;
  localparam logic [6:0] VOLUME_RESET = 7'd25;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  tune_id;
    logic [15:0] chirp_freq_hz;
    logic [15:0] chirp_ms;
  } cmd_t;

  typedef struct packed {
    logic        tone_on;
    logic [15:0] tone_freq_hz;
    logic [8:0]  pwm_duty;
    logic        busy_res;
  } res_t;

  // Duty per volume: 511 * gamma_pct(v) / 100, gamma_pct = round(100*(v/100)^2.35),
  // at least 1 for v > 0. Already folded, so no divide in hardware.
  localparam logic [8:0] VOL_DUTY [0:100] = '{
    9'd0,   9'd5,   9'd5,   9'd5,   9'd5,   9'd5,   9'd5,   9'd5,   9'd5,   9'd5,
    9'd5,   9'd5,   9'd5,   9'd5,   9'd5,   9'd5,   9'd5,   9'd10,  9'd10,  9'd10,
    9'd10,  9'd15,  9'd15,  9'd15,  9'd15,  9'd20,  9'd20,  9'd25,  9'd25,  9'd25,
    9'd30,  9'd30,  9'd35,  9'd35,  9'd40,  9'd40,  9'd45,  9'd51,  9'd51,  9'd56,
    9'd61,  9'd61,  9'd66,  9'd71,  9'd76,  9'd76,  9'd81,  9'd86,  9'd91,  9'd97,
    9'd102, 9'd107, 9'd112, 9'd112, 9'd122, 9'd127, 9'd132, 9'd137, 9'd143, 9'd148,
    9'd153, 9'd158, 9'd168, 9'd173, 9'd178, 9'd183, 9'd194, 9'd199, 9'd204, 9'd214,
    9'd219, 9'd229, 9'd235, 9'd245, 9'd250, 9'd260, 9'd265, 9'd275, 9'd286, 9'd291,
    9'd301, 9'd311, 9'd321, 9'd332, 9'd337, 9'd347, 9'd357, 9'd367, 9'd378, 9'd388,
    9'd398, 9'd408, 9'd419, 9'd429, 9'd439, 9'd454, 9'd465, 9'd475, 9'd485, 9'd500,
    9'd511
  };

  // Notes in a tune, capped at MAX_NOTES.
  function automatic logic [3:0] tune_len(input logic [2:0] t);
    logic [3:0] n;
    case (t)
      3'd0:    n = 4'd4;
      3'd1:    n = 4'd4;
      3'd2:    n = 4'd5;
      3'd3:    n = 4'd3;
      3'd4:    n = 4'd4;
      3'd5:    n = 4'd4;
      3'd6:    n = 4'd4;
      default: n = 4'd0;
    endcase
    if (n > 4'(MAX_NOTES)) begin
      n = 4'(MAX_NOTES);
    end
    return n;
  endfunction

  // Note ROM, frequency half.
  function automatic logic [15:0] note_freq(input logic [2:0] t, input logic [2:0] n);
    logic [15:0] f;
    f = 16'd0;
    case (t)
      3'd0: begin
        case (n)
          3'd0:    f = 16'd523;
          3'd1:    f = 16'd659;
          3'd2:    f = 16'd784;
          3'd3:    f = 16'd1047;
          default: f = 16'd0;
        endcase
      end
      3'd1: begin
        case (n)
          3'd0:    f = 16'd587;
          3'd1:    f = 16'd622;
          3'd2:    f = 16'd659;
          3'd3:    f = 16'd622;
          default: f = 16'd0;
        endcase
      end
      3'd2: begin
        case (n)
          3'd0:    f = 16'd784;
          3'd1:    f = 16'd523;
          3'd2:    f = 16'd784;
          3'd3:    f = 16'd523;
          3'd4:    f = 16'd392;
          default: f = 16'd0;
        endcase
      end
      3'd3: begin
        case (n)
          3'd0:    f = 16'd698;
          3'd1:    f = 16'd659;
          3'd2:    f = 16'd587;
          default: f = 16'd0;
        endcase
      end
      3'd4: begin
        case (n)
          3'd0:    f = 16'd988;
          3'd1:    f = 16'd740;
          3'd2:    f = 16'd988;
          3'd3:    f = 16'd622;
          default: f = 16'd0;
        endcase
      end
      3'd5: begin
        case (n)
          3'd0:    f = 16'd784;
          3'd1:    f = 16'd698;
          3'd2:    f = 16'd587;
          3'd3:    f = 16'd523;
          default: f = 16'd0;
        endcase
      end
      3'd6: begin
        case (n)
          3'd0:    f = 16'd523;
          3'd1:    f = 16'd659;
          3'd2:    f = 16'd784;
          3'd3:    f = 16'd988;
          default: f = 16'd0;
        endcase
      end
      default: f = 16'd0;
    endcase
    return f;
  endfunction

  // Note ROM, duration half (ms).
  function automatic logic [15:0] note_ms(input logic [2:0] t, input logic [2:0] n);
    logic [15:0] d;
    d = 16'd0;
    case (t)
      3'd0: begin
        case (n)
          3'd0, 3'd1, 3'd2: d = 16'd55;
          3'd3:             d = 16'd90;
          default:          d = 16'd0;
        endcase
      end
      3'd1: begin
        case (n)
          3'd0, 3'd1: d = 16'd70;
          3'd2:       d = 16'd90;
          3'd3:       d = 16'd55;
          default:    d = 16'd0;
        endcase
      end
      3'd2: begin
        case (n)
          3'd0, 3'd1, 3'd2, 3'd3: d = 16'd85;
          3'd4:                   d = 16'd140;
          default:                d = 16'd0;
        endcase
      end
      3'd3: begin
        case (n)
          3'd0, 3'd1: d = 16'd90;
          3'd2:       d = 16'd120;
          default:    d = 16'd0;
        endcase
      end
      3'd4: begin
        case (n)
          3'd0, 3'd1, 3'd2: d = 16'd100;
          3'd3:             d = 16'd150;
          default:          d = 16'd0;
        endcase
      end
      3'd5: begin
        case (n)
          3'd0, 3'd1: d = 16'd45;
          3'd2:       d = 16'd55;
          3'd3:       d = 16'd70;
          default:    d = 16'd0;
        endcase
      end
      3'd6: begin
        case (n)
          3'd0, 3'd1: d = 16'd40;
          3'd2:       d = 16'd55;
          3'd3:       d = 16'd75;
          default:    d = 16'd0;
        endcase
      end
      default: d = 16'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/bms_cmd_if.sv =====
// Command channel of the buzzer sequencer: valid/ready plus command fields.
// Standalone interface; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bms_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  tune_id;
  logic [15:0] chirp_freq_hz;
  logic [15:0] chirp_ms;

  modport source (output valid, output cmd, output tune_id, output chirp_freq_hz,
                  output chirp_ms, input ready);
  modport sink   (input valid, input cmd, input tune_id, input chirp_freq_hz,
                  input chirp_ms, output ready);
endinterface

`default_nettype wire

// ===== src/bms_res_if.sv =====
// Result channel of the buzzer sequencer: valid/ready plus tone status fields.
// Standalone interface; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bms_res_if;
  logic        valid;
  logic        ready;
  logic        tone_on;
  logic [15:0] tone_freq_hz;
  logic [8:0]  pwm_duty;
  logic        busy_res;

  modport source (output valid, output tone_on, output tone_freq_hz, output pwm_duty,
                  output busy_res, input ready);
  modport sink   (input valid, input tone_on, input tone_freq_hz, input pwm_duty,
                  input busy_res, output ready);
endinterface

`default_nettype wire

// ===== src/buzzer_melody_sequencer_top.sv =====
// Top level of the buzzer melody sequencer: command in, tone status out, config port.
// Depends on bms_pkg, bms_cmd_if, bms_res_if, bms_core and bms_out_buf.
//
//   channel   direction  handshake      payload
//   in_ch     in         valid/ready    cmd, tune_id, chirp_freq_hz, chirp_ms
//   out_ch    out        valid/ready    tone_on, tone_freq_hz, pwm_duty, busy_res
//   cfg_*     in         cfg_we only    cfg_index (0 enabled, 1 volume), cfg_data
//
// One item per cycle while in_ch.ready is high; results are buffered on acceptance.
// The sequencer state updates in the accepting cycle; a two-entry result buffer
// holds results, so in_ch.ready drops only while two results wait on out_ch.
// Synchronous active-low reset: buffer empty, idle and silent, disabled, volume 25.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_melody_sequencer_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  bms_cmd_if.sink         in_ch,
  bms_res_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_data
);

  logic          acc;
  logic          can_push;
  bms_pkg::cmd_t item;
  bms_pkg::res_t res;
  bms_pkg::res_t head;

  assign in_ch.ready = can_push;
  assign acc         = in_ch.valid && can_push;

  assign item.cmd           = in_ch.cmd;
  assign item.tune_id       = in_ch.tune_id;
  assign item.chirp_freq_hz = in_ch.chirp_freq_hz;
  assign item.chirp_ms      = in_ch.chirp_ms;

  bms_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .item      (item),
    .res       (res)
  );

  bms_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (acc),
    .push_data  (res),
    .can_push   (can_push),
    .pop_ready  (out_ch.ready),
    .head_valid (out_ch.valid),
    .head_data  (head)
  );

  assign out_ch.tone_on      = head.tone_on;
  assign out_ch.tone_freq_hz = head.tone_freq_hz;
  assign out_ch.pwm_duty     = head.pwm_duty;
  assign out_ch.busy_res     = head.busy_res;

endmodule

`default_nettype wire

// ===== src/bms_core.sv =====
// Sequencer state and config registers; computes the post-item tone status.
// Depends on bms_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bms_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [6:0]    cfg_data,
  input  wire logic          acc,
  input  wire bms_pkg::cmd_t item,
  output bms_pkg::res_t      res
);

  logic                enabled_r;
  logic [8:0]          vol_duty_r;   // zero exactly when volume is zero
  bms_pkg::mode_t      mode_r, mode_nxt;
  logic [2:0]          tune_r, tune_nxt;
  logic [2:0]          note_r, note_nxt;
  logic [15:0]         ms_r, ms_nxt;
  logic [15:0]         freq_r, freq_nxt;
  logic [8:0]          duty_r, duty_nxt;

  logic [6:0]          vol_sat;
  logic [2:0]          note_inc;
  logic [3:0]          cur_len;
  logic                vol_on;

  assign vol_sat  = (cfg_data > bms_pkg::VOLUME_MAX) ? bms_pkg::VOLUME_MAX : cfg_data;
  assign note_inc = note_r + 3'd1;
  assign cur_len  = bms_pkg::tune_len(tune_r);
  assign vol_on   = (vol_duty_r != 9'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      vol_duty_r <= bms_pkg::VOL_DUTY[bms_pkg::VOLUME_RESET];
    end else if (cfg_we) begin
      case (cfg_index)
        bms_pkg::CFG_ENABLED: enabled_r  <= cfg_data[0];
        bms_pkg::CFG_VOLUME:  vol_duty_r <= bms_pkg::VOL_DUTY[vol_sat];
        default:              enabled_r  <= enabled_r;
      endcase
    end
  end

  // Next state for one item.
  always_comb begin
    mode_nxt = mode_r;
    tune_nxt = tune_r;
    note_nxt = note_r;
    ms_nxt   = ms_r;
    freq_nxt = freq_r;
    duty_nxt = duty_r;
    if (acc && enabled_r) begin
      case (bms_pkg::cmd_code_t'(item.cmd))
        bms_pkg::CMD_TICK: begin
          if (mode_r == bms_pkg::MODE_TUNE) begin
            if (ms_r > 16'd1) begin
              ms_nxt = ms_r - 16'd1;
            end else begin
              freq_nxt = 16'd0;
              duty_nxt = 9'd0;
              note_nxt = note_inc;
              if (note_inc == 3'd0 || {1'b0, note_inc} >= cur_len) begin
                mode_nxt = bms_pkg::MODE_IDLE;
                ms_nxt   = 16'd0;
              end else begin
                // volume may have dropped to zero mid-tune: stay silent then
                if (vol_on && bms_pkg::note_freq(tune_r, note_inc) != 16'd0) begin
                  freq_nxt = bms_pkg::note_freq(tune_r, note_inc);
                  duty_nxt = vol_duty_r;
                end
                ms_nxt = bms_pkg::note_ms(tune_r, note_inc);
              end
            end
          end else if (mode_r == bms_pkg::MODE_CHIRP) begin
            if (ms_r > 16'd1) begin
              ms_nxt = ms_r - 16'd1;
            end else begin
              freq_nxt = 16'd0;
              duty_nxt = 9'd0;
              mode_nxt = bms_pkg::MODE_IDLE;
              ms_nxt   = 16'd0;
            end
          end
        end
        bms_pkg::CMD_START: begin
          if (vol_on && {1'b0, item.tune_id} < 4'(bms_pkg::TUNE_COUNT) &&
              bms_pkg::tune_len(item.tune_id) != 4'd0) begin
            mode_nxt = bms_pkg::MODE_TUNE;
            tune_nxt = item.tune_id;
            note_nxt = 3'd0;
            freq_nxt = bms_pkg::note_freq(item.tune_id, 3'd0);
            duty_nxt = (freq_nxt != 16'd0) ? vol_duty_r : 9'd0;
            ms_nxt   = bms_pkg::note_ms(item.tune_id, 3'd0);
          end
        end
        bms_pkg::CMD_CHIRP: begin
          if (vol_on) begin
            mode_nxt = bms_pkg::MODE_CHIRP;
            note_nxt = 3'd0;
            // 0 Hz keeps whatever tone is sounding
            if (item.chirp_freq_hz != 16'd0) begin
              freq_nxt = item.chirp_freq_hz;
              duty_nxt = vol_duty_r;
            end
            ms_nxt = item.chirp_ms;
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // Result for the item, taken from the updated state.
  always_comb begin
    res.tone_on      = (freq_nxt != 16'd0);
    res.tone_freq_hz = freq_nxt;
    res.pwm_duty     = duty_nxt;
    res.busy_res     = enabled_r && (mode_nxt != bms_pkg::MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bms_pkg::MODE_IDLE;
      tune_r <= 3'd0;
      note_r <= 3'd0;
      ms_r   <= 16'd0;
      freq_r <= 16'd0;
      duty_r <= 9'd0;
    end else begin
      mode_r <= mode_nxt;
      tune_r <= tune_nxt;
      note_r <= note_nxt;
      ms_r   <= ms_nxt;
      freq_r <= freq_nxt;
      duty_r <= duty_nxt;
    end
  end

  `BMS_ASSERT(a_idle_no_time, (mode_r == bms_pkg::MODE_IDLE) |-> (ms_r == '0), "idle timer set")
  `BMS_ASSERT(a_freq_duty_pair, (freq_r == 16'd0) == (duty_r == 9'd0), "freq/duty mismatch")
  `BMS_ASSERT(a_note_ok, (mode_r == bms_pkg::MODE_TUNE) |-> (4'(note_r) < cur_len), "note past end")

endmodule

`default_nettype wire

// ===== src/bms_out_buf.sv =====
// Two-entry result buffer: lets a new item in while a result waits downstream.
// Depends on bms_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bms_out_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire bms_pkg::res_t push_data,
  output logic               can_push,
  input  wire logic          pop_ready,
  output logic               head_valid,
  output bms_pkg::res_t      head_data
);

  logic [1:0]     count_r, count_nxt;
  bms_pkg::res_t  head_r, head_nxt;
  bms_pkg::res_t  tail_r, tail_nxt;
  logic           pop;

  assign can_push   = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_data  = head_r;
  assign pop        = head_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          head_nxt = push_data;
        end else begin
          tail_nxt = push_data;
        end
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        head_nxt  = tail_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          head_nxt = push_data;
        end else begin
          head_nxt = tail_r;
          tail_nxt = push_data;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  `BMS_ASSERT_ALWAYS(a_count_range, !rst_n || count_r != 2'd3, "buffer count out of range")
  `BMS_ASSERT(a_push_lands, (push && !pop && count_r == 2'd0) |=> (head_valid && head_r == $past(push_data)), "pushed item not at head")

endmodule

`default_nettype wire

// ===== bench/bms_checker.sv =====
// Scoreboard for the buzzer melody sequencer: watches the command, result and config ports,
// predicts the tone status of every accepted command and compares it with the block's output.
// Depends on bms_pkg, bms_cmd_if and bms_res_if.
`timescale 1ns / 1ps

module bms_checker
  import bms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  bms_cmd_if              cmd_mon,
  bms_res_if              res_mon,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_data,
  output int              mismatches,
  output int              waiting
);

  // Loudness curve, round(100*(v/100)^2.35), at least 1 above zero.
  localparam int GAMMA_PCT [0:100] = '{
     0,  1,  1,  1,  1,  1,  1,  1,  1,  1,
     1,  1,  1,  1,  1,  1,  1,  2,  2,  2,
     2,  3,  3,  3,  3,  4,  4,  5,  5,  5,
     6,  6,  7,  7,  8,  8,  9, 10, 10, 11,
    12, 12, 13, 14, 15, 15, 16, 17, 18, 19,
    20, 21, 22, 22, 24, 25, 26, 27, 28, 29,
    30, 31, 33, 34, 35, 36, 38, 39, 40, 42,
    43, 45, 46, 48, 49, 51, 52, 54, 56, 57,
    59, 61, 63, 65, 66, 68, 70, 72, 74, 76,
    78, 80, 82, 84, 86, 89, 91, 93, 95, 98,
    100
  };

  localparam logic [3:0] TUNE_NOTES [0:7] = '{4, 4, 5, 3, 4, 4, 4, 0};

  // Melody table indexed by {tune, note}.
  localparam logic [15:0] NOTE_HZ [0:63] = '{
    523, 659, 784, 1047,   0, 0, 0, 0,
    587, 622, 659,  622,   0, 0, 0, 0,
    784, 523, 784,  523, 392, 0, 0, 0,
    698, 659, 587,    0,   0, 0, 0, 0,
    988, 740, 988,  622,   0, 0, 0, 0,
    784, 698, 587,  523,   0, 0, 0, 0,
    523, 659, 784,  988,   0, 0, 0, 0,
      0,   0,   0,    0,   0, 0, 0, 0
  };

  localparam logic [15:0] NOTE_MS [0:63] = '{
     55,  55,  55,  90,   0, 0, 0, 0,
     70,  70,  90,  55,   0, 0, 0, 0,
     85,  85,  85,  85, 140, 0, 0, 0,
     90,  90, 120,   0,   0, 0, 0, 0,
    100, 100, 100, 150,   0, 0, 0, 0,
     45,  45,  55,  70,   0, 0, 0, 0,
     40,  40,  55,  75,   0, 0, 0, 0,
      0,   0,   0,   0,   0, 0, 0, 0
  };

  logic        buzzer_on;
  logic [6:0]  volume;
  mode_t       seq_mode;
  logic [2:0]  tune;
  logic [2:0]  note;
  logic [15:0] ms_left;
  logic [15:0] pitch_hz;
  logic [8:0]  duty;

  res_t        status_q[$];
  int          results_seen;

  function automatic logic [3:0] notes_in(input logic [2:0] t);
    logic [3:0] n;
    n = TUNE_NOTES[t];
    if (n > 4'(MAX_NOTES)) begin
      n = 4'(MAX_NOTES);
    end
    return n;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
             $time, results_seen, field, got, want);
    mismatches++;
  endtask

  // Zero frequency or zero volume leaves the present tone untouched.
  task automatic apply_pitch(input logic [15:0] hz);
    int pct;
    int d;
    if (!buzzer_on || hz == 16'd0 || volume == 7'd0) begin
      return;
    end
    pct = GAMMA_PCT[volume];
    d   = (511 * pct) / 100;
    if (d < 1 && pct > 0) begin
      d = 1;
    end
    pitch_hz = hz;
    duty     = 9'(d);
  endtask

  task automatic tick_ms();
    if (seq_mode == MODE_TUNE) begin
      if (ms_left > 16'd1) begin
        ms_left = ms_left - 16'd1;
      end else begin
        pitch_hz = '0;
        duty     = '0;
        note     = note + 3'd1;
        if (note == 3'd0 || {1'b0, note} >= notes_in(tune)) begin
          seq_mode = MODE_IDLE;
          ms_left  = '0;
        end else begin
          apply_pitch(NOTE_HZ[{tune, note}]);
          ms_left = NOTE_MS[{tune, note}];
        end
      end
    end else if (seq_mode == MODE_CHIRP) begin
      if (ms_left > 16'd1) begin
        ms_left = ms_left - 16'd1;
      end else begin
        pitch_hz = '0;
        duty     = '0;
        seq_mode = MODE_IDLE;
        ms_left  = '0;
      end
    end
  endtask

  task automatic step_sequencer(input cmd_t item, output res_t status);
    if (buzzer_on) begin
      case (item.cmd)
        CMD_TICK: begin
          tick_ms();
        end
        CMD_START: begin
          if (volume != 7'd0 && item.tune_id < 3'(TUNE_COUNT) && notes_in(item.tune_id) != 0)
          begin
            pitch_hz = '0;
            duty     = '0;
            seq_mode = MODE_TUNE;
            tune     = item.tune_id;
            note     = '0;
            apply_pitch(NOTE_HZ[{item.tune_id, 3'd0}]);
            ms_left = NOTE_MS[{item.tune_id, 3'd0}];
          end
        end
        CMD_CHIRP: begin
          if (volume != 7'd0) begin
            seq_mode = MODE_CHIRP;
            note     = '0;
            apply_pitch(item.chirp_freq_hz);
            ms_left = item.chirp_ms;
          end
        end
        default: begin
        end
      endcase
    end
    status.tone_on      = (pitch_hz != 16'd0);
    status.tone_freq_hz = pitch_hz;
    status.pwm_duty     = duty;
    status.busy_res     = buzzer_on && (seq_mode != MODE_IDLE);
  endtask

  always @(posedge clk) begin : watch
    cmd_t item;
    res_t want;
    if (!rst_n) begin
      buzzer_on    = 1'b0;
      volume       = VOLUME_RESET;
      seq_mode     = MODE_IDLE;
      tune         = '0;
      note         = '0;
      ms_left      = '0;
      pitch_hz     = '0;
      duty         = '0;
      results_seen = 0;
      mismatches   = 0;
      status_q.delete();
    end else begin
      // Results leave before the item of this edge can be counted.
      if (res_mon.valid && res_mon.ready) begin
        if (status_q.size() == 0) begin
          report_mismatch("result with nothing pending, tone_freq_hz",
                          res_mon.tone_freq_hz, 16'd0);
        end else begin
          want = status_q.pop_front();
          if (res_mon.tone_on !== want.tone_on) begin
            report_mismatch("tone_on", 16'(res_mon.tone_on), 16'(want.tone_on));
          end
          if (res_mon.tone_freq_hz !== want.tone_freq_hz) begin
            report_mismatch("tone_freq_hz", res_mon.tone_freq_hz, want.tone_freq_hz);
          end
          if (res_mon.pwm_duty !== want.pwm_duty) begin
            report_mismatch("pwm_duty", 16'(res_mon.pwm_duty), 16'(want.pwm_duty));
          end
          if (res_mon.busy_res !== want.busy_res) begin
            report_mismatch("busy_res", 16'(res_mon.busy_res), 16'(want.busy_res));
          end
        end
        results_seen++;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_ENABLED) begin
          buzzer_on = cfg_data[0];
        end else begin
          volume = (cfg_data > VOLUME_MAX) ? VOLUME_MAX : cfg_data;
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        item.cmd           = cmd_mon.cmd;
        item.tune_id       = cmd_mon.tune_id;
        item.chirp_freq_hz = cmd_mon.chirp_freq_hz;
        item.chirp_ms      = cmd_mon.chirp_ms;
        step_sequencer(item, want);
        status_q.push_back(want);
      end
    end
    waiting = status_q.size();
  end

endmodule

// ===== bench/tb_buzzer_melody_sequencer_top.sv =====
// Testbench top for the buzzer melody sequencer: clock, reset, command stimulus,
// register writes and result back-pressure. Checking is done in bms_checker.
// Depends on bms_pkg, bms_cmd_if, bms_res_if, bms_checker and the block's RTL.
`timescale 1ns / 1ps

module tb_buzzer_melody_sequencer_top;
  import bms_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [6:0] cfg_data;

  int         fail_count;
  int         pending;
  int         cycles = 0;
  int         items_sent = 0;
  int         burst_left = 0;

  int         rx_style = 0;
  int         rx_phase_left = 0;
  int         rx_hold = 0;

  bms_cmd_if cmd_bus ();
  bms_res_if res_bus ();

  buzzer_melody_sequencer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_bus),
    .out_ch    (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bms_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_mon    (cmd_bus),
    .res_mon    (res_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (fail_count),
    .waiting    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: style is redrawn at the end of each random-length phase, from never stalling to long stalls.
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_style      = $urandom_range(0, 3);
      rx_phase_left = $urandom_range(20, 120);
    end
    rx_phase_left--;
    case (rx_style)
      0: res_bus.ready <= 1'b1;
      1: res_bus.ready <= ($urandom_range(0, 3) != 0);
      2: res_bus.ready <= ($urandom_range(0, 9) < 3);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          res_bus.ready <= 1'b0;
        end else begin
          res_bus.ready <= 1'b1;
          if ($urandom_range(0, 4) == 0) begin
            rx_hold = $urandom_range(1, 9);
          end
        end
      end
    endcase
  end

  // Bursts of back-to-back items separated by random gaps.
  task automatic send_cmd(input cmd_t c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      repeat (gap) begin
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    cmd_bus.valid         <= 1'b1;
    cmd_bus.cmd           <= c.cmd;
    cmd_bus.tune_id       <= c.tune_id;
    cmd_bus.chirp_freq_hz <= c.chirp_freq_hz;
    cmd_bus.chirp_ms      <= c.chirp_ms;
    @(posedge clk);
    while (!cmd_bus.ready) begin
      @(posedge clk);
    end
    burst_left--;
    items_sent++;
  endtask

  task automatic send_fields(input cmd_code_t kind, input logic [2:0] t,
                             input logic [15:0] hz, input logic [15:0] ms);
    cmd_t c;
    c.cmd           = kind;
    c.tune_id       = t;
    c.chirp_freq_hz = hz;
    c.chirp_ms      = ms;
    send_cmd(c);
  endtask

  function automatic cmd_t random_fields();
    cmd_t c;
    c.cmd           = 2'($urandom_range(0, 3));
    c.tune_id       = 3'($urandom_range(0, 7));
    c.chirp_freq_hz = 16'($urandom);
    c.chirp_ms      = 16'($urandom);
    return c;
  endfunction

  task automatic send_ticks(input int n);
    cmd_t c;
    repeat (n) begin
      c     = random_fields();
      c.cmd = CMD_TICK;
      send_cmd(c);
    end
  endtask

  // Hold off until every result is back.
  task automatic drain();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly tunes followed by runs of ticks and short chirps, with some noise.
  task automatic play_random(input int n);
    int   stop_at;
    int   pick;
    int   ticks;
    cmd_t c;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      c    = random_fields();
      if (pick < 5) begin
        c.cmd     = CMD_START;
        c.tune_id = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        send_cmd(c);
        // tick run trimmed so the item budget holds
        ticks = $urandom_range(1, 110);
        if (ticks > stop_at - items_sent) begin
          ticks = stop_at - items_sent;
        end
        send_ticks(ticks);
      end else if (pick < 8) begin
        c.cmd = CMD_CHIRP;
        case ($urandom_range(0, 5))
          0:       c.chirp_freq_hz = 16'd0;
          1:       c.chirp_freq_hz = 16'($urandom);
          default: c.chirp_freq_hz = 16'($urandom_range(200, 5000));
        endcase
        if ($urandom_range(0, 3) != 0) begin
          c.chirp_ms = 16'($urandom_range(0, 8));
        end
        send_cmd(c);
        send_ticks($urandom_range(0, 8));
      end else begin
        send_cmd(c);
      end
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_ENABLED;
    cfg_data              = '0;
    cmd_bus.valid         = 1'b0;
    cmd_bus.cmd           = CMD_TICK;
    cmd_bus.tune_id       = '0;
    cmd_bus.chirp_freq_hz = '0;
    cmd_bus.chirp_ms      = '0;
    res_bus.ready         = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Disabled after reset: commands have no effect.
    send_fields(CMD_START, 3'd0, 16'd0, 16'd0);
    send_fields(CMD_CHIRP, 3'd7, 16'hFFFF, 16'hFFFF);
    drain();
    write_reg(CFG_ENABLED, 7'h01);
    write_reg(CFG_VOLUME, 7'd100);

    send_fields(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_fields(CMD_NONE, 3'd7, 16'hFFFF, 16'hFFFF);
    send_fields(CMD_START, 3'd7, 16'd0, 16'd0);        // no such tune
    send_fields(CMD_START, 3'd0, 16'd0, 16'd0);
    send_fields(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_fields(CMD_CHIRP, 3'd0, 16'd0, 16'd2);        // 0 Hz keeps the tune's tone
    send_ticks(2);
    send_fields(CMD_CHIRP, 3'd0, 16'hFFFF, 16'd0);     // zero length ends on next tick
    send_fields(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_fields(CMD_CHIRP, 3'd0, 16'd1000, 16'hFFFF);
    send_fields(CMD_START, 3'd2, 16'd0, 16'd0);        // tune cancels the chirp
    send_fields(CMD_START, 3'd4, 16'd0, 16'd0);        // restart while playing
    send_fields(CMD_CHIRP, 3'd0, 16'd0, 16'd0);
    send_fields(CMD_TICK, 3'd0, 16'd0, 16'd0);
    send_fields(CMD_START, 3'd3, 16'd0, 16'd0);
    send_fields(CMD_TICK, 3'd0, 16'd0, 16'd0);
    drain();

    // One tune played to its end.
    send_fields(CMD_START, 3'd6, 16'd0, 16'd0);
    send_ticks(214);
    drain();
    play_random(40);
    drain();

    write_reg(CFG_VOLUME, 7'd1);
    play_random(30);
    drain();

    write_reg(CFG_VOLUME, 7'h7F);                      // saturates to full volume
    play_random(30);
    drain();

    write_reg(CFG_VOLUME, 7'($urandom_range(2, 99)));
    play_random(30);
    send_fields(CMD_START, 3'd2, 16'd0, 16'd0);
    send_ticks(5);
    drain();

    // Muted: starts and chirps ignored, the running tune still advances.
    write_reg(CFG_VOLUME, 7'd0);
    play_random(25);
    drain();

    write_reg(CFG_ENABLED, 7'h7E);
    play_random(15);
    drain();

    write_reg(CFG_ENABLED, 7'h7F);
    write_reg(CFG_VOLUME, 7'd50);
    play_random(40);

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
